// ----- hdl/udpdm_pkg.sv -----
package udpdm_pkg;

   localparam logic [1:0] CMD_WRITE      = 2'd0;
   localparam logic [1:0] CMD_INVALIDATE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP     = 2'd2;

   localparam int unsigned SLOT_W  = 4;
   localparam int unsigned SCORE_W = 2;

   typedef struct packed {
      logic [15:0] peer_port;
      logic [31:0] peer_addr;
      logic [15:0] own_port;
      logic [31:0] own_addr;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_scan;
      logic last;
      logic out_free;
   } ctrl_sts_type;

endpackage

// ----- hdl/udpdm_ram.sv -----
module udpdm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/udpdm_ctrl.sv -----
module udpdm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  udpdm_pkg::ctrl_sts_type sts,
   output udpdm_pkg::ctrl_cmd_type cmd
);
   import udpdm_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_DONE} state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd        = '0;
      cmd.load   = ready_ff && req_tvalid;
      cmd.scan   = (state_ff == S_SCAN);
      cmd.finish = (state_ff == S_DONE) && sts.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = sts.start_scan ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            if (sts.last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == S_IDLE)
      else $error("ready outside idle");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && sts.last) |=> state_ff == S_LAST)
      else $error("scan did not end after last slot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !ready_ff)
      else $error("ready right after a transfer");

endmodule

// ----- hdl/udpdm_datapath.sv -----
module udpdm_datapath #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  udpdm_pkg::ctrl_cmd_type        cmd,
   output udpdm_pkg::ctrl_sts_type        sts,
   input  logic [1:0]                     req_command,
   input  logic [udpdm_pkg::SLOT_W-1:0]   req_slot,
   input  logic [31:0]                    req_key_local_ip,
   input  logic [15:0]                    req_key_local_port,
   input  logic [31:0]                    req_key_remote_ip,
   input  logic [15:0]                    req_key_remote_port,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic                           rsp_hit,
   output logic [udpdm_pkg::SLOT_W-1:0]   rsp_match_slot,
   output logic [udpdm_pkg::SCORE_W-1:0]  rsp_match_score
);
   import udpdm_pkg::*;

   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned IW = (AW > SLOT_W) ? AW : SLOT_W;
   localparam int unsigned EW = $bits(entry_type);

   logic [ENTRIES-1:0]  valid_ff;
   logic [AW-1:0]       addr_ff;
   logic                cmp_vld_ff;
   logic [AW-1:0]       cmp_idx_ff;
   logic                ent_vld_ff;
   logic [31:0]         key_lip_ff;
   logic [15:0]         key_lport_ff;
   logic [31:0]         key_rip_ff;
   logic [15:0]         key_rport_ff;
   logic                best_found_ff;
   logic [IW-1:0]       best_idx_ff;
   logic [SCORE_W-1:0]  best_score_ff;
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [SCORE_W-1:0]  rsp_score_ff;

   logic [IW-1:0]       slot_ext;
   logic [AW-1:0]       slot_addr;
   logic                slot_ok;
   logic                wr_en;
   entry_type           wr_entry;
   logic [EW-1:0]       rd_data;
   entry_type           ent;
   logic                lip_any, rip_any, rport_any;
   logic                cand;
   logic [SCORE_W-1:0]  score;
   logic                take;

   always_comb begin
      slot_ext  = IW'(req_slot);
      slot_addr = slot_ext[AW-1:0];
      slot_ok   = {1'b0, slot_ext} < (IW + 1)'(ENTRIES);
      wr_en     = cmd.load && (req_command == CMD_WRITE) && slot_ok;
      wr_entry.own_addr  = req_key_local_ip;
      wr_entry.own_port  = req_key_local_port;
      wr_entry.peer_addr = req_key_remote_ip;
      wr_entry.peer_port = req_key_remote_port;
   end

   udpdm_ram #(
      .WIDTH(EW),
      .DEPTH(ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      ent       = entry_type'(rd_data);
      lip_any   = (ent.own_addr == '0);
      rip_any   = (ent.peer_addr == '0);
      rport_any = (ent.peer_port == '0);
      cand      = ent_vld_ff && (ent.own_port == key_lport_ff)
                  && (lip_any || ent.own_addr == key_lip_ff)
                  && (rip_any || ent.peer_addr == key_rip_ff)
                  && (rport_any || ent.peer_port == key_rport_ff);
      score     = SCORE_W'({1'b0, !lip_any}) + SCORE_W'({1'b0, !rip_any})
                  + SCORE_W'({1'b0, !rport_any});
      take      = cmp_vld_ff && cand && (!best_found_ff || score >= best_score_ff);
   end

   always_comb begin
      sts            = '0;
      sts.start_scan = (req_command == CMD_LOOKUP) && (req_key_local_port != '0);
      sts.last       = (addr_ff == AW'(ENTRIES - 1));
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // slot table valid bits and scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         addr_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         best_idx_ff   <= '0;
         best_score_ff <= '0;
      end else begin
         if (cmd.load && slot_ok) begin
            if (req_command == CMD_WRITE) begin
               valid_ff[slot_addr] <= 1'b1;
            end else if (req_command == CMD_INVALIDATE) begin
               valid_ff[slot_addr] <= 1'b0;
            end
         end
         if (cmd.load) begin
            addr_ff <= '0;
         end else if (cmd.scan && !sts.last) begin
            addr_ff <= addr_ff + 1'b1;
         end
         cmp_vld_ff <= cmd.scan;
         if (cmd.load) begin
            best_found_ff <= 1'b0;
            best_idx_ff   <= '0;
            best_score_ff <= '0;
         end else if (take) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= IW'(cmp_idx_ff);
            best_score_ff <= score;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= addr_ff;
      ent_vld_ff <= valid_ff[addr_ff];
      if (cmd.load) begin
         key_lip_ff   <= req_key_local_ip;
         key_lport_ff <= req_key_local_port;
         key_rip_ff   <= req_key_remote_ip;
         key_rport_ff <= req_key_remote_port;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hit_ff   <= best_found_ff;
         rsp_slot_ff  <= best_idx_ff[SLOT_W-1:0];
         rsp_score_ff <= best_score_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_match_slot  = rsp_slot_ff;
   assign rsp_match_score = rsp_score_ff;

   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      !best_found_ff |-> (best_score_ff == '0 && best_idx_ff == '0))
      else $error("stale best match on a miss");

   a_scan_no_load: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> !cmd.load)
      else $error("request taken during a scan");

endmodule

// ----- hdl/udp_socket_demux_match_unit.sv -----
// Channel  Dir  Handshake              tdata (low bit up)                         tuser
// req      in   req_tvalid/req_tready  slot, key_local_ip, key_local_port,        command
//                                      key_remote_ip, key_remote_port
// rsp      out  rsp_tvalid/rsp_tready  match_slot, match_score                    hit
//
// Lookup: the slot scan reads one table entry per cycle from a RAM with separate read and write
// ports; each entry then passes a compare stage, and the best match goes to the result register.
// Write, invalidate, the unused command code and a lookup with destination port zero skip the scan.
// One command at a time; req_tready rises again as the result is loaded, together with rsp_tvalid.
// Reset clears all valid bits at once; table contents need no clearing.
// rsp_tready low holds the result and stalls the next command at its finish.
module udp_socket_demux_match_unit #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // slot, key_local_ip, key_local_port, key_remote_ip,
                                     // key_remote_port, zero pad
   input  logic [1:0]   req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // match_slot, match_score, zero pad
   output logic [0:0]   rsp_tuser    // hit
);
   import udpdm_pkg::*;

   ctrl_cmd_type       cmd;
   ctrl_sts_type       sts;
   logic               hit;
   logic [SLOT_W-1:0]  match_slot;
   logic [SCORE_W-1:0] match_score;

   udpdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   udpdm_datapath #(
      .ENTRIES(ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_command         (req_tuser),
      .req_slot            (req_tdata[3:0]),
      .req_key_local_ip    (req_tdata[35:4]),
      .req_key_local_port  (req_tdata[51:36]),
      .req_key_remote_ip   (req_tdata[83:52]),
      .req_key_remote_port (req_tdata[99:84]),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_hit             (hit),
      .rsp_match_slot      (match_slot),
      .rsp_match_score     (match_score)
   );

   assign rsp_tdata = {2'b00, match_score, match_slot};
   assign rsp_tuser = hit;

endmodule
